// ===== design/mono_error_diffusion_dither_macros.svh =====
// Assertion macros shared by the dither RTL.
`ifndef MONO_ERROR_DIFFUSION_DITHER_MACROS_SVH
`define MONO_ERROR_DIFFUSION_DITHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define MEDE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mede: same-cycle check failed");

// Next-cycle implication.
`define MEDE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mede: next-cycle check failed");

`else

`define MEDE_ASSERT_IMP(label, clk, rstn, ante, cons)
`define MEDE_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== design/mede_pkg.sv =====
// Types and constants of the monochrome error-diffusion ditherer.
package mede_pkg;

    localparam int BRIGHT_W    = 8;
    localparam int ROW_WIDTH_W = 11;
    localparam int BYTE_W      = 8;
    localparam int BIT_IDX_W   = 3;

    // Errors stay within +-43 (row) and +-86 (column), so 8 bits signed suffice.
    localparam int ERR_W  = 8;
    localparam int ACC_W  = 10;
    localparam int MAG_W  = 8;
    localparam int QUO_W  = 7;
    localparam int PROD_W = 16;

    localparam logic signed [ACC_W-1:0] LIGHT_THRESHOLD = 10'sd127;
    localparam logic signed [ACC_W-1:0] FULL_SCALE      = 10'sd255;

    // x/3 == (x*171) >> 9 for 0 <= x < 512
    localparam logic [MAG_W-1:0] DIV3_RECIP = 8'd171;
    localparam int               DIV3_SHIFT = 9;

    localparam logic [BIT_IDX_W-1:0] BYTE_LAST_BIT = 3'd7;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_ROW_WIDTH = 1'b0;

    typedef struct packed {
        logic [BRIGHT_W-1:0] brightness;
        logic                first_row;
    } mede_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_bits;
        logic              row_end;
    } mede_out_t;

endpackage

// ===== design/mede_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mede_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/mede_quant.sv =====
// Threshold, quantize and divide-by-three error step for one pixel.
module mede_quant (
    input  logic [mede_pkg::BRIGHT_W-1:0]     brightness,
    input  logic signed [mede_pkg::ERR_W-1:0] prev_err,
    input  logic signed [mede_pkg::ERR_W-1:0] stored_err,
    output logic                              dark,
    output logic signed [mede_pkg::ERR_W-1:0] row_err,
    output logic signed [mede_pkg::ERR_W-1:0] col_err
);

    logic signed [mede_pkg::ACC_W-1:0] acc;
    logic signed [mede_pkg::ACC_W-1:0] adj;
    logic signed [mede_pkg::ACC_W-1:0] adj_neg;
    logic                              neg;
    logic [mede_pkg::MAG_W-1:0]        mag;
    logic [mede_pkg::PROD_W-1:0]       prod;
    logic [mede_pkg::QUO_W-1:0]        quo;
    logic signed [mede_pkg::ERR_W-1:0] quo_s;

    always_comb begin
        acc = mede_pkg::ACC_W'(prev_err)
            + $signed({2'b00, brightness})
            + mede_pkg::ACC_W'(stored_err);
        dark = !(acc > mede_pkg::LIGHT_THRESHOLD);
        adj  = dark ? acc : acc - mede_pkg::FULL_SCALE;

        // truncate toward zero: divide the magnitude, then restore the sign
        neg     = adj[mede_pkg::ACC_W-1];
        adj_neg = -adj;
        mag     = neg ? adj_neg[mede_pkg::MAG_W-1:0] : adj[mede_pkg::MAG_W-1:0];
        prod    = mede_pkg::PROD_W'(mag) * mede_pkg::PROD_W'(mede_pkg::DIV3_RECIP);
        quo     = prod[mede_pkg::DIV3_SHIFT +: mede_pkg::QUO_W];
        quo_s   = $signed({1'b0, quo});
        row_err = neg ? -quo_s : quo_s;
        col_err = row_err + prev_err;
    end

endmodule

// ===== design/mono_error_diffusion_dither.sv =====
// Top level of the monochrome error-diffusion ditherer.
// Takes one brightness beat per cycle, in row order, while no full output stalls
// it, and returns one packed byte of dark-pixel bits after every eighth pixel of a
// row and at each row end (MSB = leftmost pixel, unused bits zero, row_end set on
// the last byte of a row). A byte passes the stage register and then the output
// register before it reaches m_. The column error store is one RAM with a registered
// read port, read when a pixel is accepted and written when it leaves the stage
// register, with a bypass for the one-pixel-wide row case. The store is not
// cleared: first_row must be set on every pixel of the first row of an image.
// row_width (APB address 0) is to be written only while the block is idle, a rule the
// block leaves to the user; 0 acts as 1 and values above MAX_WIDTH act as MAX_WIDTH.
`include "mono_error_diffusion_dither_macros.svh"

module mono_error_diffusion_dither #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  mede_pkg::mede_in_t                s_data,

    output logic                              m_valid,
    input  logic                              m_ready,
    output mede_pkg::mede_out_t               m_data,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mede_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mede_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mede_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int LW = (WW > mede_pkg::ROW_WIDTH_W) ? WW : mede_pkg::ROW_WIDTH_W;
    localparam int EW = mede_pkg::ERR_W;
    localparam int BW = mede_pkg::BYTE_W;

    // ---------------- configuration ----------------
    logic [mede_pkg::ROW_WIDTH_W-1:0] row_width_reg;
    logic                             reg_index;
    logic                             cfg_wr;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_wr    = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= mede_pkg::ROW_WIDTH_RESET;
        end else if (cfg_wr && reg_index == mede_pkg::REG_ROW_WIDTH) begin
            row_width_reg <= pwdata[mede_pkg::ROW_WIDTH_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_index)
            mede_pkg::REG_ROW_WIDTH: prdata = mede_pkg::APB_DATA_W'(row_width_reg);
            default:                 prdata = '0;
        endcase
    end

    // ---------------- column position ----------------
    logic [CW-1:0] column_index_reg;
    logic [CW-1:0] column_index_next;
    logic [LW-1:0] rw_ext;
    logic [LW-1:0] eff_width;
    logic [LW-1:0] col_plus;
    logic          in_last;

    always_comb begin
        rw_ext = LW'(row_width_reg);
        if (rw_ext == '0) begin
            eff_width = LW'(1);
        end else if (rw_ext > LW'(MAX_WIDTH)) begin
            eff_width = LW'(MAX_WIDTH);
        end else begin
            eff_width = rw_ext;
        end
        col_plus          = LW'(column_index_reg) + LW'(1);
        in_last           = (col_plus >= eff_width);
        column_index_next = in_last ? '0 : col_plus[CW-1:0];
    end

    // ---------------- pipeline control ----------------
    logic                st_valid_reg;
    mede_pkg::mede_in_t  st_data_reg;
    logic [CW-1:0]       st_col_reg;
    logic                st_last_reg;
    logic                st_emit;
    logic                st_go;
    logic                s_accept;
    logic                m_valid_reg;
    mede_pkg::mede_out_t m_data_reg;

    assign st_emit  = st_last_reg
                   || (st_col_reg[mede_pkg::BIT_IDX_W-1:0] == mede_pkg::BYTE_LAST_BIT);
    assign st_go    = st_valid_reg && (!st_emit || !m_valid_reg || m_ready);
    assign s_ready  = !st_valid_reg || st_go;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg     <= 1'b0;
            column_index_reg <= '0;
        end else begin
            if (s_accept) begin
                st_valid_reg     <= 1'b1;
                column_index_reg <= column_index_next;
            end else if (st_go) begin
                st_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st_data_reg <= s_data;
            st_col_reg  <= column_index_reg;
            st_last_reg <= in_last;
        end
    end

    // ---------------- column error store ----------------
    logic                 ram_wr_en;
    logic signed [EW-1:0] ram_rd_data;
    logic                 fwd_valid_reg;
    logic signed [EW-1:0] fwd_data_reg;
    logic signed [EW-1:0] col_err;
    logic signed [EW-1:0] row_err;
    logic signed [EW-1:0] stored_err;
    logic signed [EW-1:0] prev_err;
    logic signed [EW-1:0] row_err_reg;
    logic                 dark;
    logic                 first_col;

    assign ram_wr_en = st_go;

    mede_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_WIDTH)
    ) u_col_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (st_col_reg),
        .wr_data (col_err),
        .rd_en   (s_accept),
        .rd_addr (column_index_reg),
        .rd_data (ram_rd_data)
    );

    // read and write of the same entry in one cycle (one-pixel rows)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else if (s_accept) begin
            fwd_valid_reg <= ram_wr_en && (st_col_reg == column_index_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            fwd_data_reg <= col_err;
        end
    end

    assign first_col  = (st_col_reg == '0);
    assign prev_err   = first_col ? '0 : row_err_reg;
    assign stored_err = st_data_reg.first_row ? '0
                      : (fwd_valid_reg ? fwd_data_reg : ram_rd_data);

    mede_quant u_quant (
        .brightness (st_data_reg.brightness),
        .prev_err   (prev_err),
        .stored_err (stored_err),
        .dark       (dark),
        .row_err    (row_err),
        .col_err    (col_err)
    );

    // ---------------- bit packing ----------------
    logic [BW-1:0]                 byte_acc_reg;
    logic [BW-1:0]                 byte_acc_next;
    logic [mede_pkg::BIT_IDX_W-1:0] bit_pos;

    always_comb begin
        bit_pos       = mede_pkg::BYTE_LAST_BIT - st_col_reg[mede_pkg::BIT_IDX_W-1:0];
        byte_acc_next = (first_col ? '0 : byte_acc_reg) | (BW'(dark) << bit_pos);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_err_reg  <= '0;
            byte_acc_reg <= '0;
        end else if (st_go) begin
            row_err_reg  <= row_err;
            byte_acc_reg <= st_emit ? '0 : byte_acc_next;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_go && st_emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_go && st_emit) begin
            m_data_reg.packed_bits <= byte_acc_next;
            m_data_reg.row_end     <= st_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- assertions ----------------
    `MEDE_ASSERT_IMP(a_full_blocks_input, aclk, aresetn,
        st_valid_reg && st_emit && m_valid_reg && !m_ready, !s_ready)
    `MEDE_ASSERT_NEXT(a_row_wraps, aclk, aresetn,
        s_accept && in_last, column_index_reg == '0)
    `MEDE_ASSERT_NEXT(a_emit_reaches_output, aclk, aresetn,
        st_go && st_emit, m_valid_reg)

endmodule
